>>> rtl/ctc_greedy_decode_unit_macros.svh
// assertion macros used by the greedy decode core
`ifndef CTC_GREEDY_DECODE_UNIT_MACROS_SVH
`define CTC_GREEDY_DECODE_UNIT_MACROS_SVH

// same-cycle implication, clocked on aclk, quiet during reset
`define CTCGD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ctcgd check failed");

// next-cycle implication, clocked on aclk, quiet during reset
`define CTCGD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ctcgd check failed");

`endif

>>> rtl/ctcgd_pkg.sv
// package: widths, beat and config types, register map of the greedy decoder
`timescale 1ns / 1ps
package ctcgd_pkg;

    localparam int VOCAB_MAX   = 1024;
    localparam int FRAME_MAX   = 4096;
    localparam int LOGIT_BITS  = 16;

    localparam int COUNT_BITS  = $clog2(VOCAB_MAX);   // logit index / token id
    localparam int VOCAB_BITS  = 11;                  // logits per frame register
    localparam int FRAME_BITS  = 13;                  // frame counter and limit
    localparam int PADDR_BITS  = 4;
    localparam int PDATA_BITS  = 32;

    localparam logic [VOCAB_BITS-1:0] VOCAB_RESET = VOCAB_BITS'(1024);
    localparam logic [COUNT_BITS-1:0] BLANK_RESET = '0;
    localparam logic [FRAME_BITS-1:0] LIMIT_RESET = FRAME_BITS'(4096);

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_VOCAB_SIZE        = 2'd0;
    localparam logic [1:0] REG_BLANK_ID          = 2'd1;
    localparam logic [1:0] REG_VALID_FRAME_LIMIT = 2'd2;

    typedef struct packed {
        logic signed [LOGIT_BITS-1:0] logit;
        logic                         final_frame;
    } in_beat_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] frame_token;
        logic                  keep;
        logic                  utterance_end;
    } out_beat_t;

    typedef struct packed {
        logic [VOCAB_BITS-1:0] logits_per_frame;
        logic [COUNT_BITS-1:0] blank_token;
        logic [FRAME_BITS-1:0] valid_frame_limit;
    } cfg_t;

endpackage

>>> rtl/ctcgd_apb_regs.sv
// apb register file: vocab size, blank id, valid frame limit
`timescale 1ns / 1ps
module ctcgd_apb_regs
    import ctcgd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    output logic [PDATA_BITS-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[PADDR_BITS-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.logits_per_frame  <= VOCAB_RESET;
            cfg_reg.blank_token       <= BLANK_RESET;
            cfg_reg.valid_frame_limit <= LIMIT_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_VOCAB_SIZE:        cfg_reg.logits_per_frame  <= pwdata[VOCAB_BITS-1:0];
                REG_BLANK_ID:          cfg_reg.blank_token       <= pwdata[COUNT_BITS-1:0];
                REG_VALID_FRAME_LIMIT: cfg_reg.valid_frame_limit <= pwdata[FRAME_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_VOCAB_SIZE:        prdata = PDATA_BITS'(cfg_reg.logits_per_frame);
            REG_BLANK_ID:          prdata = PDATA_BITS'(cfg_reg.blank_token);
            REG_VALID_FRAME_LIMIT: prdata = PDATA_BITS'(cfg_reg.valid_frame_limit);
            default:               prdata = '0;
        endcase
    end

endmodule

>>> rtl/ctcgd_decode_core.sv
// input register, running argmax, collapse logic and result register
`timescale 1ns / 1ps
`include "ctc_greedy_decode_unit_macros.svh"
module ctcgd_decode_core
    import ctcgd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    // input register
    logic     in_valid_reg;
    in_beat_t in_beat_reg;

    // decoder state
    logic signed [LOGIT_BITS-1:0] best_value_reg, best_value_next;
    logic [COUNT_BITS-1:0]        best_index_reg, best_index_next;
    logic [COUNT_BITS-1:0]        elem_count_reg, elem_count_next;
    logic [FRAME_BITS-1:0]        frame_count_reg, frame_count_next;
    logic [COUNT_BITS-1:0]        prev_token_reg, prev_token_next;
    logic                         have_prev_reg, have_prev_next;

    // result register
    logic      out_valid_reg;
    out_beat_t out_beat_reg;

    logic                         take_new;
    logic signed [LOGIT_BITS-1:0] cand_value;
    logic [COUNT_BITS-1:0]        cand_index;
    logic [COUNT_BITS:0]          count_inc;
    logic [VOCAB_BITS-1:0]        eff_vocab;
    logic                         frame_end;
    logic                         masked;
    logic [COUNT_BITS-1:0]        token;
    logic                         keep;
    logic                         advance;

    // strict greater, so ties keep the earlier index
    assign take_new   = (elem_count_reg == '0) || (in_beat_reg.logit > best_value_reg);
    assign cand_value = take_new ? in_beat_reg.logit : best_value_reg;
    assign cand_index = take_new ? elem_count_reg : best_index_reg;
    assign count_inc  = {1'b0, elem_count_reg} + 1'b1;

    always_comb begin
        if (cfg.logits_per_frame == '0) begin
            eff_vocab = VOCAB_BITS'(1);
        end else if (cfg.logits_per_frame > VOCAB_BITS'(VOCAB_MAX)) begin
            eff_vocab = VOCAB_BITS'(VOCAB_MAX);
        end else begin
            eff_vocab = cfg.logits_per_frame;
        end
    end

    assign frame_end = VOCAB_BITS'(count_inc) >= eff_vocab;
    assign masked    = frame_count_reg >= cfg.valid_frame_limit;
    assign token     = masked ? cfg.blank_token : cand_index;
    assign keep      = (!have_prev_reg || token != prev_token_reg) && token != cfg.blank_token;

    // a beat that closes a frame needs room in the result register
    assign advance = in_valid_reg && (!frame_end || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        best_value_next  = best_value_reg;
        best_index_next  = best_index_reg;
        elem_count_next  = elem_count_reg;
        frame_count_next = frame_count_reg;
        prev_token_next  = prev_token_reg;
        have_prev_next   = have_prev_reg;
        if (advance) begin
            if (!frame_end) begin
                best_value_next = cand_value;
                best_index_next = cand_index;
                elem_count_next = count_inc[COUNT_BITS-1:0];
            end else if (in_beat_reg.final_frame) begin
                best_value_next  = '0;
                best_index_next  = '0;
                elem_count_next  = '0;
                frame_count_next = '0;
                prev_token_next  = '0;
                have_prev_next   = 1'b0;
            end else begin
                best_value_next = '0;
                best_index_next = '0;
                elem_count_next = '0;
                prev_token_next = token;
                have_prev_next  = 1'b1;
                if (frame_count_reg < FRAME_BITS'(FRAME_MAX)) begin
                    frame_count_next = frame_count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            best_value_reg  <= '0;
            best_index_reg  <= '0;
            elem_count_reg  <= '0;
            frame_count_reg <= '0;
            prev_token_reg  <= '0;
            have_prev_reg   <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance && frame_end) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            best_value_reg  <= best_value_next;
            best_index_reg  <= best_index_next;
            elem_count_reg  <= elem_count_next;
            frame_count_reg <= frame_count_next;
            prev_token_reg  <= prev_token_next;
            have_prev_reg   <= have_prev_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_beat_reg <= s_data;
        end
        if (advance && frame_end) begin
            out_beat_reg.frame_token   <= token;
            out_beat_reg.keep          <= keep;
            out_beat_reg.utterance_end <= in_beat_reg.final_frame;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_beat_reg;

    // the input stage only stalls behind a full, unaccepted result
    `CTCGD_ASSERT_NOW(a_stall_only_when_full, in_valid_reg && !advance, out_valid_reg && !m_ready)
    // frame counter never moves without a previous token
    `CTCGD_ASSERT_NOW(a_count_needs_prev, !have_prev_reg, frame_count_reg == '0)
    // end of utterance returns the decoder to its idle state
    `CTCGD_ASSERT_NEXT(a_utt_end_clears,
        advance && frame_end && in_beat_reg.final_frame,
        elem_count_reg == '0 && frame_count_reg == '0 && !have_prev_reg && m_valid)
    // a closed frame restarts the argmax and leaves a previous token
    `CTCGD_ASSERT_NEXT(a_frame_end_restarts,
        advance && frame_end && !in_beat_reg.final_frame,
        elem_count_reg == '0 && have_prev_reg && m_valid)

endmodule

>>> rtl/ctc_greedy_decode_unit.sv
// top level of the streaming greedy ctc decoder
`timescale 1ns / 1ps
//  channel | direction | handshake          | beat
//  s_      | in        | s_valid / s_ready  | in_beat_t: logit, final_frame
//  m_      | out       | m_valid / m_ready  | out_beat_t: frame_token, keep, utterance_end
//  apb     | in        | psel/penable/pready| logits_per_frame, blank_token, valid_frame_limit
//
// one logit beat per cycle unless the input side stalls; the argmax compare and
// collapse select sit between the input register and the result register, and a
// frame result is registered when its last logit beat leaves the input register.
// synchronous active-low reset clears decoder state; registers return to defaults.
// the input side stalls only when a frame-closing beat finds the result register
// full and not being taken.
module ctc_greedy_decode_unit
    import ctcgd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_beat_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_beat_t             m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    output logic [PDATA_BITS-1:0] prdata,
    output logic                  pready
);

    cfg_t cfg;

    ctcgd_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ctcgd_decode_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
